FILE: hw/rtl/tfe_pkg.sv
package tfe_pkg;

    // Upper bound on the output buffer, terminator included
    localparam int C_MAX_LEN   = 4096;
    localparam int C_CFG_W     = 14;
    localparam int C_BUF_DEPTH = 5;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_YEAR         = 3'd0,
        CFG_MONTH_INDEX  = 3'd1,
        CFG_DAY_OF_MONTH = 3'd2,
        CFG_HOUR         = 3'd3,
        CFG_MINUTE       = 3'd4,
        CFG_SECOND       = 3'd5,
        CFG_WEEKDAY      = 3'd6,
        CFG_MAX_SIZE     = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [13:0] C_RST_YEAR     = 14'd1970;
    localparam logic [4:0]  C_RST_DAY      = 5'd1;
    localparam logic [2:0]  C_RST_WEEKDAY  = 3'd4;
    localparam logic [12:0] C_RST_MAX_SIZE = 13'd256;

    // Characters and conversion letters
    localparam logic [7:0] C_CH_NUL  = 8'h00;
    localparam logic [7:0] C_CH_PCT  = "%";
    localparam logic [7:0] C_CH_ZERO = "0";

    localparam logic [7:0] C_CONV_WDAY_NAME = "a";
    localparam logic [7:0] C_CONV_MON_NAME  = "b";
    localparam logic [7:0] C_CONV_YEAR      = "Y";
    localparam logic [7:0] C_CONV_MONTH     = "m";
    localparam logic [7:0] C_CONV_DAY       = "d";
    localparam logic [7:0] C_CONV_HOUR      = "H";
    localparam logic [7:0] C_CONV_MINUTE    = "M";
    localparam logic [7:0] C_CONV_SECOND    = "S";
    localparam logic [7:0] C_CONV_ZONE_NAME = "Z";
    localparam logic [7:0] C_CONV_ZONE_OFS  = "z";
    localparam logic [7:0] C_CONV_WDAY_SUN0 = "w";
    localparam logic [7:0] C_CONV_WDAY_MON1 = "u";

    localparam logic [23:0] C_TXT_UTC  = "UTC";
    localparam logic [39:0] C_TXT_OFS  = "+0000";

    // Kind of work an accepted byte starts
    typedef enum logic [1:0] {
        K_NONE,     // percent lead-in, nothing to output
        K_TEXT,     // bytes staged at once
        K_NUMBER,   // decimal digits still to be built
        K_STATUS    // terminator, status result
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIGIT,
        S_CHECK,
        S_EMIT,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic accept;
        logic digit;
        logic check;
        logic emit;
        logic status;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  dig_last;
        logic  chk_empty;
        logic  emit_last;
        logic  out_free;
    } t_stat;

    function automatic logic [23:0] day_name(input logic [2:0] wd);
        logic [23:0] s;
        case (wd)
            3'd0:    s = "Sun";
            3'd1:    s = "Mon";
            3'd2:    s = "Tue";
            3'd3:    s = "Wed";
            3'd4:    s = "Thu";
            3'd5:    s = "Fri";
            3'd6:    s = "Sat";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [23:0] mon_name(input logic [3:0] mi);
        logic [23:0] s;
        case (mi)
            4'd0:    s = "Jan";
            4'd1:    s = "Feb";
            4'd2:    s = "Mar";
            4'd3:    s = "Apr";
            4'd4:    s = "May";
            4'd5:    s = "Jun";
            4'd6:    s = "Jul";
            4'd7:    s = "Aug";
            4'd8:    s = "Sep";
            4'd9:    s = "Oct";
            4'd10:   s = "Nov";
            4'd11:   s = "Dec";
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/time_format_expander.sv
// Time format expander. Feed a zero-terminated format string one byte per
// transaction on the format channel; each plain byte comes back as one text
// result, and percent conversions (%a %b %Y %m %d %H %M %S %w %u %Z %z %%)
// expand from the time fields in the configuration registers. The zero byte
// returns one status result with the text length, or overflow when the text
// plus terminator would not fit in min(max_size, 4096) bytes; after overflow
// no more text comes out for that string. last_of_run marks the final result
// of each input byte. The user must write configuration only while no string
// byte is in flight, through i_cfg_we/index/data; the block itself does not
// enforce it. One byte is worked on at a time: a percent byte is only accepted;
// a plain byte, %%, a name or a fixed string is accepted, checked for size and
// sent byte by byte; a numeric conversion first builds its digits through a
// single divide-by-ten step; the terminator sends one status result. Each
// sent byte waits on the output register; a stalled result channel holds it.
module time_format_expander import tfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // format byte channel
    input  logic               i_format_valid,
    output logic               o_format_ready,
    input  logic [7:0]         i_format_char,
    // result channel
    output logic               o_result_valid,
    input  logic               i_result_ready,
    output logic [7:0]         o_out_char,
    output logic               o_char_valid,
    output logic               o_last_of_run,
    output logic               o_done_res,
    output logic               o_overflow,
    output logic [11:0]        o_text_length,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [C_CFG_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: accept, digit loop, size check, byte emission, status
    tfe_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_format_valid (i_format_valid),
        .i_stat         (stat),
        .o_format_ready (o_format_ready),
        .o_cmd          (cmd)
    );

    // registers, staging buffer, digit unit, size check, output register
    tfe_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_format_char  (i_format_char),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_result_ready (i_result_ready),
        .o_result_valid (o_result_valid),
        .o_out_char     (o_out_char),
        .o_char_valid   (o_char_valid),
        .o_last_of_run  (o_last_of_run),
        .o_done_res     (o_done_res),
        .o_overflow     (o_overflow),
        .o_text_length  (o_text_length)
    );

endmodule

FILE: hw/rtl/tfe_ctrl.sv
module tfe_ctrl import tfe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_format_valid,
    input  t_stat i_stat,
    output logic  o_format_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_format_valid) begin
                    case (i_stat.kind)
                        K_STATUS: n_state = S_STATUS;
                        K_TEXT:   n_state = S_CHECK;
                        K_NUMBER: n_state = S_DIGIT;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_DIGIT: begin
                if (i_stat.dig_last) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_stat.chk_empty ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) n_state = S_IDLE;
            end
            S_STATUS: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_format_ready = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                o_format_ready = 1'b1;
                o_cmd.accept   = i_format_valid;
            end
            S_DIGIT:  o_cmd.digit  = 1'b1;
            S_CHECK:  o_cmd.check  = 1'b1;
            S_EMIT:   o_cmd.emit   = i_stat.out_free;
            S_STATUS: o_cmd.status = i_stat.out_free;
            default: begin
                o_format_ready = 1'b0;
            end
        endcase
    end

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_stat.out_free) |=> (r_state == S_EMIT))
        else $error("emit state left while output register busy");

    a_digit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT && !i_stat.dig_last) |=> (r_state == S_DIGIT))
        else $error("digit loop cut short");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

endmodule

FILE: hw/rtl/tfe_datapath.sv
module tfe_datapath import tfe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [7:0]           i_format_char,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [C_CFG_W-1:0]   i_cfg_data,
    input  logic                 i_result_ready,
    output logic                 o_result_valid,
    output logic [7:0]           o_out_char,
    output logic                 o_char_valid,
    output logic                 o_last_of_run,
    output logic                 o_done_res,
    output logic                 o_overflow,
    output logic [11:0]          o_text_length
);

    localparam logic [12:0] LP_MAX_LEN = 13'(C_MAX_LEN);

    // configuration
    logic [13:0] r_year;
    logic [3:0]  r_month_index;
    logic [4:0]  r_day_of_month;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;
    logic [2:0]  r_weekday;
    logic [12:0] r_max_size;

    // string state
    logic        r_ap;
    logic [12:0] r_wp;
    logic        r_ovf;

    // staging
    logic [7:0]  r_buf [C_BUF_DEPTH];
    logic [2:0]  r_n;
    logic        r_unk;
    logic [13:0] r_num;
    logic [2:0]  r_dig_cnt;
    logic [2:0]  r_emit_left;
    logic [2:0]  r_ptr;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_cv;
    logic        r_out_last;
    logic        r_out_done;
    logic        r_out_ovf;
    logic [11:0] r_out_len;

    // staging decode
    t_kind       s_kind;
    logic [7:0]  s_buf [C_BUF_DEPTH];
    logic [2:0]  s_n;
    logic        s_unk;
    logic        s_ap;
    logic [13:0] s_num;
    logic [2:0]  s_width;
    logic [2:0]  s_digits;
    logic [23:0] s_name;

    // digit step
    logic [29:0] dig_prod;
    logic [10:0] dig_q;
    logic [13:0] dig_rem;
    logic [7:0]  dig_char;

    // size check
    logic [12:0] eff_max;
    logic [13:0] sum1, sum2, sumn;
    logic        fit1, fit2, fitn;
    logic [2:0]  chk_k;
    logic        chk_set;
    logic        end_ovf;
    logic        out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year         <= C_RST_YEAR;
            r_month_index  <= '0;
            r_day_of_month <= C_RST_DAY;
            r_hour         <= '0;
            r_minute       <= '0;
            r_second       <= '0;
            r_weekday      <= C_RST_WEEKDAY;
            r_max_size     <= C_RST_MAX_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_YEAR:         r_year         <= i_cfg_data[13:0];
                CFG_MONTH_INDEX:  r_month_index  <= i_cfg_data[3:0];
                CFG_DAY_OF_MONTH: r_day_of_month <= i_cfg_data[4:0];
                CFG_HOUR:         r_hour         <= i_cfg_data[4:0];
                CFG_MINUTE:       r_minute       <= i_cfg_data[5:0];
                CFG_SECOND:       r_second       <= i_cfg_data[5:0];
                CFG_WEEKDAY:      r_weekday      <= i_cfg_data[2:0];
                CFG_MAX_SIZE:     r_max_size     <= i_cfg_data[12:0];
                default:          r_year         <= r_year;
            endcase
        end
    end

    // classify and stage the incoming byte
    always_comb begin
        s_kind  = K_TEXT;
        s_buf   = r_buf;
        s_n     = 3'd0;
        s_unk   = 1'b0;
        s_ap    = 1'b0;
        s_num   = '0;
        s_width = 3'd1;
        s_name  = '0;
        if (i_format_char == C_CH_NUL) begin
            s_kind = K_STATUS;
        end else if (!r_ap) begin
            if (i_format_char == C_CH_PCT) begin
                s_kind = K_NONE;
                s_ap   = 1'b1;
            end else begin
                s_buf[4] = i_format_char;
                s_n      = 3'd1;
            end
        end else begin
            case (i_format_char)
                C_CH_PCT: begin
                    s_buf[4] = C_CH_PCT;
                    s_n      = 3'd1;
                end
                C_CONV_WDAY_NAME, C_CONV_MON_NAME: begin
                    if (i_format_char == C_CONV_WDAY_NAME) begin
                        s_name = day_name(r_weekday);
                        s_n    = (r_weekday < 3'd7) ? 3'd3 : 3'd0;
                    end else begin
                        s_name = mon_name(r_month_index);
                        s_n    = (r_month_index < 4'd12) ? 3'd3 : 3'd0;
                    end
                    s_buf[2] = s_name[23:16];
                    s_buf[3] = s_name[15:8];
                    s_buf[4] = s_name[7:0];
                end
                C_CONV_YEAR: begin
                    s_kind  = K_NUMBER;
                    s_num   = r_year;
                    s_width = 3'd4;
                end
                C_CONV_MONTH: begin
                    s_kind  = K_NUMBER;
                    s_num   = 14'(r_month_index) + 14'd1;
                    s_width = 3'd2;
                end
                C_CONV_DAY: begin
                    s_kind  = K_NUMBER;
                    s_num   = 14'(r_day_of_month);
                    s_width = 3'd2;
                end
                C_CONV_HOUR: begin
                    s_kind  = K_NUMBER;
                    s_num   = 14'(r_hour);
                    s_width = 3'd2;
                end
                C_CONV_MINUTE: begin
                    s_kind  = K_NUMBER;
                    s_num   = 14'(r_minute);
                    s_width = 3'd2;
                end
                C_CONV_SECOND: begin
                    s_kind  = K_NUMBER;
                    s_num   = 14'(r_second);
                    s_width = 3'd2;
                end
                C_CONV_WDAY_SUN0: begin
                    s_kind = K_NUMBER;
                    s_num  = 14'(r_weekday);
                end
                C_CONV_WDAY_MON1: begin
                    s_kind = K_NUMBER;
                    s_num  = (r_weekday == 3'd0) ? 14'd7 : 14'(r_weekday);
                end
                C_CONV_ZONE_NAME: begin
                    s_buf[2] = C_TXT_UTC[23:16];
                    s_buf[3] = C_TXT_UTC[15:8];
                    s_buf[4] = C_TXT_UTC[7:0];
                    s_n      = 3'd3;
                end
                C_CONV_ZONE_OFS: begin
                    s_buf[0] = C_TXT_OFS[39:32];
                    s_buf[1] = C_TXT_OFS[31:24];
                    s_buf[2] = C_TXT_OFS[23:16];
                    s_buf[3] = C_TXT_OFS[15:8];
                    s_buf[4] = C_TXT_OFS[7:0];
                    s_n      = 3'd5;
                end
                default: begin
                    // unknown: percent and letter, each checked on its own
                    s_buf[3] = C_CH_PCT;
                    s_buf[4] = i_format_char;
                    s_n      = 3'd2;
                    s_unk    = 1'b1;
                end
            endcase
        end

        if (s_num < 14'd10)         s_digits = 3'd1;
        else if (s_num < 14'd100)   s_digits = 3'd2;
        else if (s_num < 14'd1000)  s_digits = 3'd3;
        else if (s_num < 14'd10000) s_digits = 3'd4;
        else                        s_digits = 3'd5;

        if (s_kind == K_NUMBER) begin
            s_n = (s_digits > s_width) ? s_digits : s_width;
        end
    end

    // one decimal digit per cycle: divide by ten through the reciprocal
    assign dig_prod = 30'(r_num) * 30'd52429;
    assign dig_q    = dig_prod[29:19];
    assign dig_rem  = r_num - (14'({dig_q, 3'b000}) + 14'({dig_q, 1'b0}));
    assign dig_char = C_CH_ZERO + {4'b0000, dig_rem[3:0]};

    // size check
    assign eff_max = (r_max_size < LP_MAX_LEN) ? r_max_size : LP_MAX_LEN;
    assign sum1    = 14'(r_wp) + 14'd1;
    assign sum2    = 14'(r_wp) + 14'd2;
    assign sumn    = 14'(r_wp) + 14'(r_n);
    assign fit1    = sum1 < 14'(eff_max);
    assign fit2    = sum2 < 14'(eff_max);
    assign fitn    = sumn < 14'(eff_max);

    always_comb begin
        chk_k   = 3'd0;
        chk_set = 1'b0;
        if (!r_ovf && r_n != 3'd0) begin
            if (r_unk) begin
                if (!fit1) begin
                    chk_set = 1'b1;
                end else if (!fit2) begin
                    chk_k   = 3'd1;
                    chk_set = 1'b1;
                end else begin
                    chk_k = 3'd2;
                end
            end else if (fitn) begin
                chk_k = r_n;
            end else begin
                chk_set = 1'b1;
            end
        end
    end

    assign end_ovf  = r_ovf || (r_wp >= eff_max);
    assign out_free = !r_out_valid || i_result_ready;

    assign o_stat.kind      = s_kind;
    assign o_stat.dig_last  = (r_dig_cnt == 3'd0);
    assign o_stat.chk_empty = (chk_k == 3'd0);
    assign o_stat.emit_last = (r_emit_left == 3'd1);
    assign o_stat.out_free  = out_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ap        <= 1'b0;
            r_wp        <= '0;
            r_ovf       <= 1'b0;
            r_dig_cnt   <= '0;
            r_emit_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_ap      <= s_ap;
                r_dig_cnt <= 3'(C_BUF_DEPTH - 1);
            end
            if (i_cmd.digit) begin
                r_dig_cnt <= r_dig_cnt - 3'd1;
            end
            if (i_cmd.check) begin
                r_wp        <= r_wp + 13'(chk_k);
                r_ovf       <= r_ovf | chk_set;
                r_emit_left <= chk_k;
            end
            if (i_cmd.emit) begin
                r_emit_left <= r_emit_left - 3'd1;
            end
            if (i_cmd.status) begin
                r_wp  <= '0;
                r_ovf <= 1'b0;
                r_ap  <= 1'b0;
            end
            if (i_cmd.emit || i_cmd.status) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_buf <= s_buf;
            r_n   <= s_n;
            r_unk <= s_unk;
            r_num <= s_num;
        end else if (i_cmd.digit) begin
            // least significant digit first, shifted toward the tail
            r_num    <= 14'(dig_q);
            r_buf[0] <= dig_char;
            for (int i = 1; i < C_BUF_DEPTH; i++) begin
                r_buf[i] <= r_buf[i-1];
            end
        end
        if (i_cmd.check) begin
            r_ptr <= 3'(C_BUF_DEPTH) - r_n;
        end else if (i_cmd.emit) begin
            r_ptr <= r_ptr + 3'd1;
        end
        if (i_cmd.emit) begin
            r_out_char <= r_buf[r_ptr];
            r_out_cv   <= 1'b1;
            r_out_last <= (r_emit_left == 3'd1);
            r_out_done <= 1'b0;
            r_out_ovf  <= 1'b0;
            r_out_len  <= '0;
        end else if (i_cmd.status) begin
            r_out_char <= '0;
            r_out_cv   <= 1'b0;
            r_out_last <= 1'b1;
            r_out_done <= 1'b1;
            r_out_ovf  <= end_ovf;
            r_out_len  <= end_ovf ? 12'd0 : r_wp[11:0];
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_char_valid   = r_out_cv;
    assign o_last_of_run  = r_out_last;
    assign o_done_res     = r_out_done;
    assign o_overflow     = r_out_ovf;
    assign o_text_length  = r_out_len;

    a_emit_in_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit_left != 3'd0) |-> (4'(r_ptr) + 4'(r_emit_left) <= 4'(C_BUF_DEPTH)))
        else $error("emit window runs past staging buffer");

    a_emit_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_emit_left != 3'd0))
        else $error("emit with nothing left to send");

    a_ovf_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done && r_out_ovf) |-> (r_out_len == 12'd0))
        else $error("overflow status carries a length");

endmodule

FILE: tb/tfe_checker.sv
`timescale 1ns / 1ps

module tfe_checker import tfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fmt_valid,
    input  logic               i_fmt_ready,
    input  logic [7:0]         i_fmt_char,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [7:0]         i_out_char,
    input  logic               i_char_valid,
    input  logic               i_last_of_run,
    input  logic               i_done_res,
    input  logic               i_overflow,
    input  logic [11:0]        i_text_length,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [C_CFG_W-1:0] i_cfg_data,
    output int                 o_err_count,
    output int                 o_open_count
);

    typedef struct packed {
        logic [7:0]  ch;
        logic        cv;
        logic        last;
        logic        done;
        logic        ovf;
        logic [11:0] len;
    } t_res;

    localparam logic [167:0] C_DAY_TXT = "SunMonTueWedThuFriSat";
    localparam logic [287:0] C_MON_TXT = "JanFebMarAprMayJunJulAugSepOctNovDec";

    // shadow of the time registers
    logic [13:0] year;
    logic [3:0]  month_idx;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  wday;
    logic [12:0] max_size;

    // expander state
    logic        after_pct;
    logic        ovf_flag;
    int          wpos;
    logic [7:0]  stg [5];
    int          stg_len;

    t_res        run_q [$];
    t_res        text_expect_q [$];

    initial begin
        o_err_count  = 0;
        o_open_count = 0;
    end

    function automatic int eff_size();
        return (int'(max_size) < C_MAX_LEN) ? int'(max_size) : C_MAX_LEN;
    endfunction

    // n bytes, first byte in the most significant position of the n-byte text
    task automatic stage_text(input logic [39:0] txt, input int n);
        for (int i = 0; i < n; i++)
            stg[i] = txt[8*(n-1-i) +: 8];
        stg_len = n;
    endtask

    task automatic stage_digits(input int unsigned v, input int w);
        logic [7:0] tmp [5];
        int         n;
        n = 0;
        do begin
            tmp[n] = 8'(C_CH_ZERO + v % 10);
            n++;
            v = v / 10;
        end while (v != 0 && n < 5);
        while (n < w && n < 5) begin
            tmp[n] = C_CH_ZERO;
            n++;
        end
        for (int i = 0; i < n; i++)
            stg[i] = tmp[n-1-i];
        stg_len = n;
    endtask

    // whole conversion goes out, or the string overflows
    task automatic flush_staged();
        t_res r;
        if (ovf_flag || stg_len == 0) begin
            stg_len = 0;
            return;
        end
        if (wpos + stg_len >= eff_size()) begin
            ovf_flag = 1'b1;
            stg_len  = 0;
            return;
        end
        for (int i = 0; i < stg_len; i++) begin
            r    = '0;
            r.ch = stg[i];
            r.cv = 1'b1;
            run_q.push_back(r);
        end
        wpos    = wpos + stg_len;
        stg_len = 0;
    endtask

    task automatic predict_byte(input logic [7:0] c);
        t_res r;
        logic ovf_now;
        run_q.delete();
        if (c == C_CH_NUL) begin
            ovf_now = ovf_flag || (wpos >= eff_size());
            r       = '0;
            r.last  = 1'b1;
            r.done  = 1'b1;
            r.ovf   = ovf_now;
            r.len   = ovf_now ? 12'd0 : 12'(wpos);
            text_expect_q.push_back(r);
            after_pct = 1'b0;
            wpos      = 0;
            ovf_flag  = 1'b0;
            stg_len   = 0;
            return;
        end
        if (!after_pct) begin
            if (c == C_CH_PCT) begin
                after_pct = 1'b1;
                return;
            end
            stage_text({32'd0, c}, 1);
        end else begin
            after_pct = 1'b0;
            case (c)
                C_CH_PCT:         stage_text({32'd0, C_CH_PCT}, 1);
                C_CONV_WDAY_NAME: begin
                    if (wday < 3'd7) stage_text({16'd0, C_DAY_TXT[167 - 24*wday -: 24]}, 3);
                    else stg_len = 0;
                end
                C_CONV_MON_NAME:  begin
                    if (month_idx < 4'd12)
                        stage_text({16'd0, C_MON_TXT[287 - 24*month_idx -: 24]}, 3);
                    else stg_len = 0;
                end
                C_CONV_YEAR:      stage_digits(year, 4);
                C_CONV_MONTH:     stage_digits(month_idx + 1, 2);
                C_CONV_DAY:       stage_digits(mday, 2);
                C_CONV_HOUR:      stage_digits(hour, 2);
                C_CONV_MINUTE:    stage_digits(minute, 2);
                C_CONV_SECOND:    stage_digits(second, 2);
                C_CONV_ZONE_NAME: stage_text({16'd0, C_TXT_UTC}, 3);
                C_CONV_ZONE_OFS:  stage_text(C_TXT_OFS, 5);
                C_CONV_WDAY_SUN0: stage_digits(wday, 1);
                C_CONV_WDAY_MON1: stage_digits((wday == 3'd0) ? 7 : wday, 1);
                default: begin
                    // unknown letter: percent and letter are sized separately
                    stage_text({32'd0, C_CH_PCT}, 1);
                    flush_staged();
                    stage_text({32'd0, c}, 1);
                end
            endcase
        end
        flush_staged();
        if (run_q.size() > 0) begin
            r      = run_q.pop_back();
            r.last = 1'b1;
            run_q.push_back(r);
        end
        foreach (run_q[i])
            text_expect_q.push_back(run_q[i]);
    endtask

    task automatic write_shadow(input logic [2:0] idx, input logic [C_CFG_W-1:0] data);
        case (t_cfg_idx'(idx))
            CFG_YEAR:         year      = data[13:0];
            CFG_MONTH_INDEX:  month_idx = data[3:0];
            CFG_DAY_OF_MONTH: mday      = data[4:0];
            CFG_HOUR:         hour      = data[4:0];
            CFG_MINUTE:       minute    = data[5:0];
            CFG_SECOND:       second    = data[5:0];
            CFG_WEEKDAY:      wday      = data[2:0];
            CFG_MAX_SIZE:     max_size  = data[12:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_err_count++;
        end
    endtask

    task automatic check_result();
        t_res w;
        if (text_expect_q.size() == 0) begin
            $error("result transaction with nothing expected: out_char 0x%0h done_res %0b",
                   i_out_char, i_done_res);
            o_err_count++;
            return;
        end
        w = text_expect_q.pop_front();
        check_field("out_char",    w.ch,   i_out_char);
        check_field("char_valid",  w.cv,   i_char_valid);
        check_field("last_of_run", w.last, i_last_of_run);
        check_field("done_res",    w.done, i_done_res);
        check_field("overflow",    w.ovf,  i_overflow);
        check_field("text_length", w.len,  i_text_length);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            year      = C_RST_YEAR;
            month_idx = '0;
            mday      = C_RST_DAY;
            hour      = '0;
            minute    = '0;
            second    = '0;
            wday      = C_RST_WEEKDAY;
            max_size  = C_RST_MAX_SIZE;
            after_pct = 1'b0;
            ovf_flag  = 1'b0;
            wpos      = 0;
            stg_len   = 0;
            text_expect_q.delete();
        end else begin
            if (i_cfg_we)
                write_shadow(i_cfg_index, i_cfg_data);
            if (i_fmt_valid && i_fmt_ready)
                predict_byte(i_fmt_char);
            if (i_res_valid && i_res_ready)
                check_result();
        end
        o_open_count = text_expect_q.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb import tfe_pkg::*; ();

    // Cycles with no transaction on either channel before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off plus a settle pause.
    localparam int IDLE_LIMIT    = 3000;
    // Cycles to let the block drain after the last expected result; covers a
    // numeric conversion that ends up producing nothing (overflowed string).
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 200;
    localparam int RAND_ITEMS    = 100;

    typedef enum int {
        SINK_FREE,      // always ready
        SINK_COIN,      // ready on a coin flip
        SINK_PERIODIC,  // one stall per random period
        SINK_SLOW       // mostly stalled
    } t_sink_mode;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               fmt_valid = 1'b0;
    logic               fmt_ready;
    logic [7:0]         fmt_char  = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic [7:0]         res_char;
    logic               res_cv;
    logic               res_last;
    logic               res_done;
    logic               res_ovf;
    logic [11:0]        res_len;
    logic               cfg_we    = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [C_CFG_W-1:0] cfg_data  = '0;

    int                 err_count;
    int                 open_count;

    // sender burst bookkeeping
    int                 burst_left = 0;
    int                 items_sent = 0;
    // asks the result sink for one long hold-off while bytes keep coming
    logic               press_req  = 1'b0;
    logic               press_done = 1'b0;
    int                 idle_cycles = 0;

    always #5 clk = ~clk;

    time_format_expander i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_format_valid (fmt_valid),
        .o_format_ready (fmt_ready),
        .i_format_char  (fmt_char),
        .o_result_valid (res_valid),
        .i_result_ready (res_ready),
        .o_out_char     (res_char),
        .o_char_valid   (res_cv),
        .o_last_of_run  (res_last),
        .o_done_res     (res_done),
        .o_overflow     (res_ovf),
        .o_text_length  (res_len),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // Predicts every result from the format transactions and config writes it
    // sees, and scores the result channel against it.
    tfe_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_fmt_valid   (fmt_valid),
        .i_fmt_ready   (fmt_ready),
        .i_fmt_char    (fmt_char),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_out_char    (res_char),
        .i_char_valid  (res_cv),
        .i_last_of_run (res_last),
        .i_done_res    (res_done),
        .i_overflow    (res_ovf),
        .i_text_length (res_len),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_err_count   (err_count),
        .o_open_count  (open_count)
    );

    // One format byte. Bursts of random length; between bursts the valid usually
    // drops for a random gap. Valid stays up across back-to-back bytes of a burst.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0) begin
            fmt_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        fmt_valid <= 1'b1;
        fmt_char  <= c;
        do @(posedge clk); while (!fmt_ready);
        items_sent++;
    endtask

    // Format string plus its terminator.
    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(8'(s[i]));
        send_byte(C_CH_NUL);
    endtask

    // Drop valid, wait for every predicted result, then give the block time to
    // finish any byte that produces nothing. After this the block is idle.
    task automatic settle();
        @(negedge clk);
        fmt_valid <= 1'b0;
        while (open_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= C_CFG_W'(data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_time(input int unsigned yr, input int unsigned mo,
                              input int unsigned dy, input int unsigned hr,
                              input int unsigned mi, input int unsigned sc,
                              input int unsigned wd, input int unsigned sz);
        write_reg(CFG_YEAR,         yr);
        write_reg(CFG_MONTH_INDEX,  mo);
        write_reg(CFG_DAY_OF_MONTH, dy);
        write_reg(CFG_HOUR,         hr);
        write_reg(CFG_MINUTE,       mi);
        write_reg(CFG_SECOND,       sc);
        write_reg(CFG_WEEKDAY,      wd);
        write_reg(CFG_MAX_SIZE,     sz);
    endtask

    // Random value of a w-bit field, biased toward both ends.
    function automatic int unsigned field_value(input int w);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return (1 << w) - 1;
            default: return $urandom_range(0, (1 << w) - 1);
        endcase
    endfunction

    // Buffer size: mostly small so overflow happens often, sometimes past the
    // 4096 clamp.
    function automatic int unsigned size_value();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return $urandom_range(1, 3);
            2, 3, 4: return $urandom_range(4, 40);
            5:       return $urandom_range(41, 300);
            6:       return C_MAX_LEN + $urandom_range(0, 1);
            default: return $urandom_range(C_MAX_LEN + 2, (1 << 13) - 1);
        endcase
    endfunction

    task automatic shuffle_regs();
        settle();
        if ($urandom_range(0, 1)) write_reg(CFG_YEAR,         field_value(14));
        if ($urandom_range(0, 1)) write_reg(CFG_MONTH_INDEX,  field_value(4));
        if ($urandom_range(0, 1)) write_reg(CFG_DAY_OF_MONTH, field_value(5));
        if ($urandom_range(0, 1)) write_reg(CFG_HOUR,         field_value(5));
        if ($urandom_range(0, 1)) write_reg(CFG_MINUTE,       field_value(6));
        if ($urandom_range(0, 1)) write_reg(CFG_SECOND,       field_value(6));
        if ($urandom_range(0, 1)) write_reg(CFG_WEEKDAY,      field_value(3));
        write_reg(CFG_MAX_SIZE, size_value());
    endtask

    function automatic logic [7:0] conv_code(input int unsigned sel);
        case (sel)
            0:       return C_CONV_WDAY_NAME;
            1:       return C_CONV_MON_NAME;
            2:       return C_CONV_YEAR;
            3:       return C_CONV_MONTH;
            4:       return C_CONV_DAY;
            5:       return C_CONV_HOUR;
            6:       return C_CONV_MINUTE;
            7:       return C_CONV_SECOND;
            8:       return C_CONV_ZONE_NAME;
            9:       return C_CONV_ZONE_OFS;
            10:      return C_CONV_WDAY_SUN0;
            11:      return C_CONV_WDAY_MON1;
            default: return C_CH_PCT;
        endcase
    endfunction

    // Mostly well-formed strings: plain bytes and known conversions. Some
    // unknown conversions and a trailing lone percent act as noise.
    task automatic send_random_string();
        int          n_tok;
        int          pick;
        logic [7:0]  b;
        n_tok = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
        repeat (n_tok) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                b = 8'($urandom_range(1, 255));
                send_byte(b);
                // keep a plain percent from swallowing the next token
                if (b == C_CH_PCT)
                    send_byte(C_CH_PCT);
            end else if (pick < 85) begin
                send_byte(C_CH_PCT);
                send_byte(conv_code($urandom_range(0, 12)));
            end else begin
                send_byte(C_CH_PCT);
                send_byte(8'($urandom_range(1, 255)));
            end
        end
        if ($urandom_range(0, 9) == 0)
            send_byte(C_CH_PCT);
        send_byte(C_CH_NUL);
    endtask

    // Result sink: stall patterns of random kind and length, plus one long
    // hold-off once the random traffic has started so the block backs up into
    // the format channel.
    initial begin : result_sink
        t_sink_mode mode;
        int         span;
        int         period;
        forever begin
            if (press_req && !press_done) begin
                @(negedge clk);
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                press_done = 1'b1;
            end
            mode   = t_sink_mode'($urandom_range(0, 3));
            span   = $urandom_range(5, 60);
            period = $urandom_range(2, 5);
            for (int k = 0; k < span; k++) begin
                @(negedge clk);
                case (mode)
                    SINK_FREE:     res_ready <= 1'b1;
                    SINK_COIN:     res_ready <= 1'($urandom_range(0, 1));
                    SINK_PERIODIC: res_ready <= ((k % period) != 0);
                    default:       res_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Hang detector: any transaction on either channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (fmt_valid && fmt_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int rand_base;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Every conversion with the reset time (Thu Jan 1970-01-01 00:00:00).
        send_str("%a%b%Y%m%d%H%M%S%w%u%Z%z%%");

        // Top of every field: empty weekday and month names, weekday 7 for %u,
        // five-digit year, month 16, a 0xFF byte, an unknown conversion and a
        // lone percent before the terminator.
        settle();
        write_time((1 << 14) - 1, 15, 31, 31, 63, 63, 7, (1 << 13) - 1);
        send_str("%a%b%u%Y%m%d%H%M%S\377%q%");

        // Bottom of every field but the month, Sunday. Size 5: the percent of an unknown
        // conversion fits but its letter does not.
        settle();
        write_time(0, 11, 0, 0, 0, 0, 0, 5);
        send_str("abc%q");
        // %u gives 7 for Sunday, %w gives 0, then the month name overflows
        send_str("%u%w%b");

        // Zero size: even an empty string is an overflow.
        settle();
        write_reg(CFG_MAX_SIZE, 0);
        send_str("");

        // Size shrinks mid-string below what is already written: the
        // terminator must report overflow.
        settle();
        write_reg(CFG_MAX_SIZE, 8);
        send_byte("a");
        send_byte("b");
        send_byte("c");
        send_byte("d");
        settle();
        write_reg(CFG_MAX_SIZE, 4);
        send_byte(C_CH_NUL);

        // Random strings, occasionally with new register values in between.
        // No register shuffle until the long hold-off is over, so bytes keep
        // coming while the result side is held.
        settle();
        write_reg(CFG_MAX_SIZE, C_MAX_LEN + 1);
        press_req = 1'b1;
        rand_base = items_sent;
        while (items_sent - rand_base < RAND_ITEMS) begin
            if (press_done && $urandom_range(0, 3) == 0)
                shuffle_regs();
            send_random_string();
        end

        settle();
        if (err_count == 0 && open_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
